FILE: src/ecomp_pkg.sv
// ----------------------------------------------------------------------------
// ecomp_pkg: shared types and microcode for the sensor compensation core
// Holds the micro-op encoding, scratch slot names, coefficient field codes
// and the compensation program run by the sequencer.
// ----------------------------------------------------------------------------
package ecomp_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned PC_W      = 8;

  localparam logic [23:0] RAW_SKIP = 24'h800000;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP     = 3'd0;
  localparam logic [2:0] CFG_PRESS_LO = 3'd1;
  localparam logic [2:0] CFG_PRESS_HI = 3'd2;
  localparam logic [2:0] CFG_MIXED    = 3'd3;
  localparam logic [2:0] CFG_HUM      = 3'd4;

  typedef enum logic [4:0] {
    OP_LDF, OP_MOVB, OP_ADD, OP_SUB, OP_AND, OP_SHL, OP_ASR, OP_DIVP,
    OP_S32, OP_MAX0, OP_MIN, OP_MUL, OP_DIV, OP_TSTZ, OP_STFT, OP_OUTT,
    OP_OUTP, OP_OUTH, OP_END
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] dst;
    logic [SLOT_W-1:0] sa;
    logic [SLOT_W-1:0] sb;
    logic              bimm;
    logic [31:0]       imm;
  } instr_t;

  // operand field codes for OP_LDF
  localparam logic [4:0] F_ADC_T = 5'd0;
  localparam logic [4:0] F_ADC_P = 5'd1;
  localparam logic [4:0] F_RH    = 5'd2;
  localparam logic [4:0] F_FT    = 5'd3;
  localparam logic [4:0] F_T1    = 5'd4;
  localparam logic [4:0] F_T2    = 5'd5;
  localparam logic [4:0] F_T3    = 5'd6;
  localparam logic [4:0] F_P1    = 5'd7;
  localparam logic [4:0] F_P2    = 5'd8;
  localparam logic [4:0] F_P3    = 5'd9;
  localparam logic [4:0] F_P4    = 5'd10;
  localparam logic [4:0] F_P5    = 5'd11;
  localparam logic [4:0] F_P6    = 5'd12;
  localparam logic [4:0] F_P7    = 5'd13;
  localparam logic [4:0] F_P8    = 5'd14;
  localparam logic [4:0] F_P9    = 5'd15;
  localparam logic [4:0] F_H1    = 5'd16;
  localparam logic [4:0] F_H2    = 5'd17;
  localparam logic [4:0] F_H3    = 5'd18;
  localparam logic [4:0] F_H4    = 5'd19;
  localparam logic [4:0] F_H5    = 5'd20;
  localparam logic [4:0] F_H6    = 5'd21;

  localparam logic [SLOT_W-1:0] R0  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] R1  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] R2  = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] R3  = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] R4  = SLOT_W'(4);
  localparam logic [SLOT_W-1:0] R5  = SLOT_W'(5);
  localparam logic [SLOT_W-1:0] R6  = SLOT_W'(6);
  localparam logic [SLOT_W-1:0] R7  = SLOT_W'(7);
  localparam logic [SLOT_W-1:0] R8  = SLOT_W'(8);
  localparam logic [SLOT_W-1:0] R9  = SLOT_W'(9);
  localparam logic [SLOT_W-1:0] R10 = SLOT_W'(10);

  function automatic instr_t i_rr(op_e op, logic [SLOT_W-1:0] d, logic [SLOT_W-1:0] a,
                                  logic [SLOT_W-1:0] b);
    instr_t r;
    r.op   = op;
    r.dst  = d;
    r.sa   = a;
    r.sb   = b;
    r.bimm = 1'b0;
    r.imm  = 32'd0;
    return r;
  endfunction

  function automatic instr_t i_ri(op_e op, logic [SLOT_W-1:0] d, logic [SLOT_W-1:0] a,
                                  logic [31:0] imm);
    instr_t r;
    r.op   = op;
    r.dst  = d;
    r.sa   = a;
    r.sb   = R0;
    r.bimm = 1'b1;
    r.imm  = imm;
    return r;
  endfunction

  function automatic instr_t i_ld(logic [SLOT_W-1:0] d, logic [4:0] f);
    return i_ri(OP_LDF, d, R0, {27'd0, f});
  endfunction

  // compensation program: temperature, pressure, humidity
  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      8'd0:   r = i_ld(R1, F_ADC_T);
      8'd1:   r = i_ld(R2, F_T1);
      8'd2:   r = i_ri(OP_ASR, R3, R1, 32'd3);
      8'd3:   r = i_rr(OP_ADD, R4, R2, R2);
      8'd4:   r = i_rr(OP_SUB, R3, R3, R4);
      8'd5:   r = i_rr(OP_S32, R3, R3, R0);
      8'd6:   r = i_ld(R5, F_T2);
      8'd7:   r = i_rr(OP_MUL, R3, R3, R5);
      8'd8:   r = i_rr(OP_S32, R3, R3, R0);
      8'd9:   r = i_ri(OP_DIVP, R3, R3, 32'd11);
      8'd10:  r = i_ri(OP_ASR, R4, R1, 32'd4);
      8'd11:  r = i_rr(OP_SUB, R4, R4, R2);
      8'd12:  r = i_rr(OP_S32, R4, R4, R0);
      8'd13:  r = i_rr(OP_MUL, R4, R4, R4);
      8'd14:  r = i_rr(OP_S32, R4, R4, R0);
      8'd15:  r = i_ri(OP_DIVP, R4, R4, 32'd12);
      8'd16:  r = i_ld(R5, F_T3);
      8'd17:  r = i_rr(OP_MUL, R4, R4, R5);
      8'd18:  r = i_rr(OP_S32, R4, R4, R0);
      8'd19:  r = i_ri(OP_DIVP, R4, R4, 32'd14);
      8'd20:  r = i_rr(OP_ADD, R3, R3, R4);
      8'd21:  r = i_rr(OP_S32, R3, R3, R0);
      8'd22:  r = i_rr(OP_STFT, R0, R3, R0);
      8'd23:  r = i_ri(OP_MUL, R3, R3, 32'd5);
      8'd24:  r = i_ri(OP_ADD, R3, R3, 32'd128);
      8'd25:  r = i_rr(OP_S32, R3, R3, R0);
      8'd26:  r = i_ri(OP_DIVP, R3, R3, 32'd8);
      8'd27:  r = i_rr(OP_OUTT, R0, R3, R0);
      // pressure, 64-bit working width
      8'd28:  r = i_ld(R1, F_FT);
      8'd29:  r = i_ri(OP_ADD, R1, R1, 32'hFFFE_0C00); // minus 128000
      8'd30:  r = i_rr(OP_MUL, R2, R1, R1);
      8'd31:  r = i_ld(R3, F_P6);
      8'd32:  r = i_rr(OP_MUL, R4, R2, R3);
      8'd33:  r = i_ld(R3, F_P5);
      8'd34:  r = i_rr(OP_MUL, R5, R1, R3);
      8'd35:  r = i_ri(OP_SHL, R5, R5, 32'd17);
      8'd36:  r = i_rr(OP_ADD, R4, R4, R5);
      8'd37:  r = i_ld(R3, F_P4);
      8'd38:  r = i_ri(OP_SHL, R3, R3, 32'd35);
      8'd39:  r = i_rr(OP_ADD, R4, R4, R3);
      8'd40:  r = i_ld(R3, F_P3);
      8'd41:  r = i_rr(OP_MUL, R5, R2, R3);
      8'd42:  r = i_ri(OP_ASR, R5, R5, 32'd8);
      8'd43:  r = i_ld(R3, F_P2);
      8'd44:  r = i_rr(OP_MUL, R6, R1, R3);
      8'd45:  r = i_ri(OP_SHL, R6, R6, 32'd12);
      8'd46:  r = i_rr(OP_ADD, R5, R5, R6);
      8'd47:  r = i_ri(OP_MOVB, R6, R0, 32'd1);
      8'd48:  r = i_ri(OP_SHL, R6, R6, 32'd47);
      8'd49:  r = i_rr(OP_ADD, R5, R5, R6);
      8'd50:  r = i_ld(R3, F_P1);
      8'd51:  r = i_rr(OP_MUL, R5, R5, R3);
      8'd52:  r = i_ri(OP_ASR, R5, R5, 32'd33);
      8'd53:  r = i_rr(OP_TSTZ, R0, R5, R0);
      8'd54:  r = i_ld(R6, F_ADC_P);
      8'd55:  r = i_ri(OP_MOVB, R7, R0, 32'd1048576);
      8'd56:  r = i_rr(OP_SUB, R7, R7, R6);
      8'd57:  r = i_ri(OP_SHL, R7, R7, 32'd31);
      8'd58:  r = i_rr(OP_SUB, R7, R7, R4);
      8'd59:  r = i_ri(OP_MUL, R7, R7, 32'd3125);
      8'd60:  r = i_rr(OP_DIV, R7, R7, R5);
      8'd61:  r = i_ri(OP_ASR, R8, R7, 32'd13);
      8'd62:  r = i_ld(R3, F_P9);
      8'd63:  r = i_rr(OP_MUL, R9, R3, R8);
      8'd64:  r = i_rr(OP_MUL, R9, R9, R8);
      8'd65:  r = i_ri(OP_ASR, R9, R9, 32'd25);
      8'd66:  r = i_ld(R3, F_P8);
      8'd67:  r = i_rr(OP_MUL, R10, R3, R7);
      8'd68:  r = i_ri(OP_ASR, R10, R10, 32'd19);
      8'd69:  r = i_rr(OP_ADD, R7, R7, R9);
      8'd70:  r = i_rr(OP_ADD, R7, R7, R10);
      8'd71:  r = i_ri(OP_ASR, R7, R7, 32'd8);
      8'd72:  r = i_ld(R3, F_P7);
      8'd73:  r = i_ri(OP_SHL, R3, R3, 32'd4);
      8'd74:  r = i_rr(OP_ADD, R7, R7, R3);
      8'd75:  r = i_ri(OP_ASR, R8, R7, 32'd8);
      8'd76:  r = i_ri(OP_MUL, R8, R8, 32'd1000);
      8'd77:  r = i_ri(OP_AND, R9, R7, 32'd255);
      // frac * 390625 / 100000 is exactly frac * 125 / 32
      8'd78:  r = i_ri(OP_MUL, R9, R9, 32'd125);
      8'd79:  r = i_ri(OP_ASR, R9, R9, 32'd5);
      8'd80:  r = i_rr(OP_ADD, R8, R8, R9);
      8'd81:  r = i_rr(OP_OUTP, R0, R8, R0);
      // humidity, 32-bit working width
      8'd82:  r = i_ld(R1, F_FT);
      8'd83:  r = i_ri(OP_ADD, R1, R1, 32'hFFFE_D400); // minus 76800
      8'd84:  r = i_rr(OP_S32, R1, R1, R0);
      8'd85:  r = i_ld(R2, F_RH);
      8'd86:  r = i_ri(OP_SHL, R2, R2, 32'd14);
      8'd87:  r = i_ld(R3, F_H4);
      8'd88:  r = i_ri(OP_SHL, R3, R3, 32'd20);
      8'd89:  r = i_rr(OP_S32, R3, R3, R0);
      8'd90:  r = i_rr(OP_SUB, R2, R2, R3);
      8'd91:  r = i_rr(OP_S32, R2, R2, R0);
      8'd92:  r = i_ld(R3, F_H5);
      8'd93:  r = i_rr(OP_MUL, R3, R3, R1);
      8'd94:  r = i_rr(OP_S32, R3, R3, R0);
      8'd95:  r = i_rr(OP_SUB, R2, R2, R3);
      8'd96:  r = i_rr(OP_S32, R2, R2, R0);
      8'd97:  r = i_ri(OP_ADD, R2, R2, 32'd16384);
      8'd98:  r = i_rr(OP_S32, R2, R2, R0);
      8'd99:  r = i_ri(OP_ASR, R2, R2, 32'd15);
      8'd100: r = i_ld(R3, F_H6);
      8'd101: r = i_rr(OP_MUL, R3, R1, R3);
      8'd102: r = i_rr(OP_S32, R3, R3, R0);
      8'd103: r = i_ri(OP_ASR, R3, R3, 32'd10);
      8'd104: r = i_ld(R4, F_H3);
      8'd105: r = i_rr(OP_MUL, R4, R1, R4);
      8'd106: r = i_rr(OP_S32, R4, R4, R0);
      8'd107: r = i_ri(OP_ASR, R4, R4, 32'd11);
      8'd108: r = i_ri(OP_ADD, R4, R4, 32'd32768);
      8'd109: r = i_rr(OP_S32, R4, R4, R0);
      8'd110: r = i_rr(OP_MUL, R3, R3, R4);
      8'd111: r = i_rr(OP_S32, R3, R3, R0);
      8'd112: r = i_ri(OP_ASR, R3, R3, 32'd10);
      8'd113: r = i_ri(OP_ADD, R3, R3, 32'd2097152);
      8'd114: r = i_rr(OP_S32, R3, R3, R0);
      8'd115: r = i_ld(R4, F_H2);
      8'd116: r = i_rr(OP_MUL, R3, R3, R4);
      8'd117: r = i_rr(OP_S32, R3, R3, R0);
      8'd118: r = i_ri(OP_ADD, R3, R3, 32'd8192);
      8'd119: r = i_rr(OP_S32, R3, R3, R0);
      8'd120: r = i_ri(OP_ASR, R3, R3, 32'd14);
      8'd121: r = i_rr(OP_MUL, R2, R2, R3);
      8'd122: r = i_rr(OP_S32, R2, R2, R0);
      8'd123: r = i_ri(OP_ASR, R3, R2, 32'd15);
      8'd124: r = i_rr(OP_MUL, R3, R3, R3);
      8'd125: r = i_rr(OP_S32, R3, R3, R0);
      8'd126: r = i_ri(OP_ASR, R3, R3, 32'd7);
      8'd127: r = i_ld(R4, F_H1);
      8'd128: r = i_rr(OP_MUL, R3, R3, R4);
      8'd129: r = i_rr(OP_S32, R3, R3, R0);
      8'd130: r = i_ri(OP_ASR, R3, R3, 32'd4);
      8'd131: r = i_rr(OP_SUB, R2, R2, R3);
      8'd132: r = i_rr(OP_S32, R2, R2, R0);
      8'd133: r = i_rr(OP_MAX0, R2, R2, R0);
      8'd134: r = i_ri(OP_MIN, R2, R2, 32'd419430400);
      8'd135: r = i_rr(OP_OUTH, R0, R2, R0);
      default: r = i_rr(OP_END, R0, R0, R0);
    endcase
    return r;
  endfunction

endpackage

FILE: src/ecomp_ram.sv
// ----------------------------------------------------------------------------
// ecomp_ram: generic scratch ram
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ecomp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: src/env_sensor_compensation_core.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_core: integer compensation of raw sensor samples
// Temperature, pressure and humidity from one raw sample set.
// ----------------------------------------------------------------------------
// Each accepted item runs a fixed micro-program of 136 steps on one shared
// 64-bit datapath: a 32x32 multiplier that builds each 64-bit product from
// partial products, a radix-2 divider for the one pressure quotient, and a
// 16-entry scratch ram whose read data is registered. An item's result is
// offered only after the program has reached its end step; the
// input is not ready meanwhile. A finished result waits in the output
// register, so the next item may be accepted before it is taken. The fine
// temperature is kept across items and is only updated by a valid temperature.
// Coefficient writes are taken at any time but belong in idle periods.
module env_sensor_compensation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_temperature [23:0], raw_pressure [47:24], raw_humidity [63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // temperature_centi [31:0], pressure_milli_pa [63:32], humidity_q10 [80:64]
  output logic [87:0] m_axis_tdata,
  // temperature_ok [0], pressure_ok [1]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_WB   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q;
  logic [ecomp_pkg::PC_W-1:0] pc_q;
  ecomp_pkg::instr_t instr;

  logic [47:0] tcoef_q;
  logic [63:0] plo_q, phi_q;
  logic [47:0] mix_q;
  logic [39:0] hcoef_q;

  logic [23:0] rt_q, rp_q;
  logic [15:0] rh_q;
  logic        skip_q, pz_q;
  logic [31:0] fine_q, tc_q, pres_q;
  logic [16:0] hout_q;

  logic [31:0] o_tc_q, o_pres_q;
  logic [16:0] o_hum_q;
  logic        o_tok_q, o_pok_q, mvalid_q;

  logic [63:0] ma_q, mb_q, prod_q, macc_q;
  logic [1:0]  mstep_q;
  logic [31:0] mx, my;

  logic [63:0] dq_q, drem_q, dden_q;
  logic        dneg_q;
  logic [5:0]  dcnt_q;
  logic [64:0] dtrial, ddiff;
  logic        dge;

  logic [63:0] res_q;
  logic        wneg_q;

  logic [63:0] rd_a, rd_b, opb, fld, alu, rmask, wdata;
  logic [5:0]  sh;
  logic        we, alu_wr;

  assign instr = ecomp_pkg::prog(pc_q);

  ecomp_ram #(
    .WIDTH(64),
    .DEPTH(ecomp_pkg::NUM_SLOTS)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (instr.dst),
    .wdata_i  (wdata),
    .raddr_a_i(instr.sa),
    .raddr_b_i(instr.sb),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  // coefficient and input field selection, sign or zero extended to 64 bits
  always_comb begin
    case (instr.imm[4:0])
      ecomp_pkg::F_ADC_T: fld = {44'd0, rt_q[23:4]};
      ecomp_pkg::F_ADC_P: fld = {44'd0, rp_q[23:4]};
      ecomp_pkg::F_RH:    fld = {48'd0, rh_q};
      ecomp_pkg::F_FT:    fld = {{32{fine_q[31]}}, fine_q};
      ecomp_pkg::F_T1:    fld = {48'd0, tcoef_q[15:0]};
      ecomp_pkg::F_T2:    fld = {{48{tcoef_q[31]}}, tcoef_q[31:16]};
      ecomp_pkg::F_T3:    fld = {{48{tcoef_q[47]}}, tcoef_q[47:32]};
      ecomp_pkg::F_P1:    fld = {48'd0, plo_q[15:0]};
      ecomp_pkg::F_P2:    fld = {{48{plo_q[31]}}, plo_q[31:16]};
      ecomp_pkg::F_P3:    fld = {{48{plo_q[47]}}, plo_q[47:32]};
      ecomp_pkg::F_P4:    fld = {{48{plo_q[63]}}, plo_q[63:48]};
      ecomp_pkg::F_P5:    fld = {{48{phi_q[15]}}, phi_q[15:0]};
      ecomp_pkg::F_P6:    fld = {{48{phi_q[31]}}, phi_q[31:16]};
      ecomp_pkg::F_P7:    fld = {{48{phi_q[47]}}, phi_q[47:32]};
      ecomp_pkg::F_P8:    fld = {{48{phi_q[63]}}, phi_q[63:48]};
      ecomp_pkg::F_P9:    fld = {{48{mix_q[15]}}, mix_q[15:0]};
      ecomp_pkg::F_H1:    fld = {56'd0, mix_q[23:16]};
      ecomp_pkg::F_H2:    fld = {{48{mix_q[39]}}, mix_q[39:24]};
      ecomp_pkg::F_H3:    fld = {56'd0, mix_q[47:40]};
      ecomp_pkg::F_H4:    fld = {{48{hcoef_q[15]}}, hcoef_q[15:0]};
      ecomp_pkg::F_H5:    fld = {{48{hcoef_q[31]}}, hcoef_q[31:16]};
      ecomp_pkg::F_H6:    fld = {{56{hcoef_q[39]}}, hcoef_q[39:32]};
      default:            fld = 64'd0;
    endcase
  end

  always_comb begin
    opb    = instr.bimm ? {{32{instr.imm[31]}}, instr.imm} : rd_b;
    sh     = instr.imm[5:0];
    rmask  = (64'd1 << sh) - 64'd1;
    alu_wr = 1'b1;
    case (instr.op)
      ecomp_pkg::OP_LDF:  alu = fld;
      ecomp_pkg::OP_MOVB: alu = opb;
      ecomp_pkg::OP_ADD:  alu = rd_a + opb;
      ecomp_pkg::OP_SUB:  alu = rd_a - opb;
      ecomp_pkg::OP_AND:  alu = rd_a & opb;
      ecomp_pkg::OP_SHL:  alu = rd_a << sh;
      ecomp_pkg::OP_ASR:  alu = 64'($signed(rd_a) >>> sh);
      // divide by a power of two, truncating toward zero
      ecomp_pkg::OP_DIVP: alu = 64'($signed(rd_a + (rd_a[63] ? rmask : 64'd0)) >>> sh);
      ecomp_pkg::OP_S32:  alu = {{32{rd_a[31]}}, rd_a[31:0]};
      ecomp_pkg::OP_MAX0: alu = rd_a[63] ? 64'd0 : rd_a;
      ecomp_pkg::OP_MIN:  alu = ($signed(rd_a) < $signed(opb)) ? rd_a : opb;
      default: begin
        alu    = rd_a;
        alu_wr = 1'b0;
      end
    endcase
  end

  // shared multiplier: low x low, low x high, high x low
  assign mx = (mstep_q == 2'd2) ? ma_q[63:32] : ma_q[31:0];
  assign my = (mstep_q == 2'd1) ? mb_q[63:32] : mb_q[31:0];

  // restoring divider step on magnitudes
  assign dtrial = {drem_q, dq_q[63]};
  assign ddiff  = dtrial - {1'b0, dden_q};
  assign dge    = !ddiff[64];

  always_comb begin
    we    = 1'b0;
    wdata = alu;
    if (state_q == S_EXEC) begin
      we = alu_wr;
    end else if (state_q == S_WB) begin
      we    = 1'b1;
      wdata = wneg_q ? 64'd0 - res_q : res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      mvalid_q <= 1'b0;
      fine_q   <= 32'd0;
      tcoef_q  <= '0;
      plo_q    <= '0;
      phi_q    <= '0;
      mix_q    <= '0;
      hcoef_q  <= '0;
      mstep_q  <= '0;
      dcnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ecomp_pkg::CFG_TEMP:     tcoef_q <= cfg_data_i[47:0];
          ecomp_pkg::CFG_PRESS_LO: plo_q   <= cfg_data_i;
          ecomp_pkg::CFG_PRESS_HI: phi_q   <= cfg_data_i;
          ecomp_pkg::CFG_MIXED:    mix_q   <= cfg_data_i[47:0];
          ecomp_pkg::CFG_HUM:      hcoef_q <= cfg_data_i[39:0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        mvalid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            rt_q    <= s_axis_tdata[23:0];
            rp_q    <= s_axis_tdata[47:24];
            rh_q    <= s_axis_tdata[63:48];
            skip_q  <= (s_axis_tdata[23:0] == ecomp_pkg::RAW_SKIP);
            tc_q    <= 32'd0;
            pc_q    <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          state_q <= S_READ;
          pc_q    <= pc_q + 1'b1;
          case (instr.op)
            ecomp_pkg::OP_MUL: begin
              ma_q    <= rd_a;
              mb_q    <= opb;
              mstep_q <= 2'd0;
              pc_q    <= pc_q;
              state_q <= S_MUL;
            end
            ecomp_pkg::OP_DIV: begin
              dq_q    <= rd_a[63] ? 64'd0 - rd_a : rd_a;
              dden_q  <= opb[63] ? 64'd0 - opb : opb;
              drem_q  <= 64'd0;
              dneg_q  <= rd_a[63] ^ opb[63];
              dcnt_q  <= '0;
              pc_q    <= pc_q;
              state_q <= S_DIV;
            end
            ecomp_pkg::OP_TSTZ: pz_q <= (rd_a == 64'd0);
            ecomp_pkg::OP_STFT: begin
              if (!skip_q) begin
                fine_q <= rd_a[31:0];
              end
            end
            ecomp_pkg::OP_OUTT: begin
              if (!skip_q) begin
                tc_q <= rd_a[31:0];
              end
            end
            ecomp_pkg::OP_OUTP: pres_q <= pz_q ? 32'd0 : rd_a[31:0];
            ecomp_pkg::OP_OUTH: hout_q <= rd_a[28:12];
            ecomp_pkg::OP_END: begin
              pc_q    <= pc_q;
              state_q <= S_OUT;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          prod_q  <= mx * my;
          mstep_q <= mstep_q + 1'b1;
          case (mstep_q)
            2'd1: macc_q <= prod_q;
            2'd2: macc_q <= macc_q + {prod_q[31:0], 32'd0};
            2'd3: begin
              res_q   <= macc_q + {prod_q[31:0], 32'd0};
              wneg_q  <= 1'b0;
              state_q <= S_WB;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          drem_q <= dge ? ddiff[63:0] : dtrial[63:0];
          dq_q   <= {dq_q[62:0], dge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 6'd63) begin
            res_q   <= {dq_q[62:0], dge};
            wneg_q  <= dneg_q;
            state_q <= S_WB;
          end
        end
        S_WB: begin
          pc_q    <= pc_q + 1'b1;
          state_q <= S_READ;
        end
        S_OUT: begin
          if (!mvalid_q || m_axis_tready) begin
            o_tc_q   <= tc_q;
            o_tok_q  <= !skip_q;
            o_pres_q <= pres_q;
            o_pok_q  <= !pz_q;
            o_hum_q  <= hout_q;
            mvalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {7'd0, o_hum_q, o_pres_q, o_tc_q};
  assign m_axis_tuser  = {o_pok_q, o_tok_q};

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == S_READ)
    else $error("accepted item did not start the program");
  a_pres_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[63:32] == 32'd0)
    else $error("pressure not zero with zero divisor");
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[80:64] <= 17'd102400)
    else $error("humidity above clamp");
`endif

endmodule
